FILE: rtl/ascii_binary_expression_calculator_assert.svh
// Assertion macros for the ASCII expression calculator.
// Each macro expects clk and rst in scope; no other dependencies.
`ifndef ASCII_BINARY_EXPRESSION_CALCULATOR_ASSERT_SVH
`define ASCII_BINARY_EXPRESSION_CALCULATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define ABC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ascii calculator: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define ABC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ascii calculator: next-cycle check failed");

`endif

FILE: rtl/abc_pkg.sv
// Shared types, constants and helpers for the ASCII expression calculator.
// No dependencies; every other file but the assertion header imports this package.
`timescale 1ns / 1ps
`default_nettype none

package abc_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned ERR_W         = 2;
  localparam int unsigned ABC_QUEUE_DEPTH = 2;
  localparam int unsigned DIV_CNT_W     = $clog2(DATA_W);

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OPER = 2'd1;
  localparam logic [ERR_W-1:0] ERR_DIV0 = 2'd2;

  // Parser phase
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // Operator class, decided in the front end
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_BAD
  } op_t;

  // Execution unit state
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } back_state_t;

  // One parsed expression, handed from front to back
  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    op_t               op;
  } job_t;

  function automatic op_t op_classify(input logic [CHAR_W-1:0] c);
    op_t r;
    unique case (c)
      CH_PLUS:  r = OP_ADD;
      CH_MINUS: r = OP_SUB;
      CH_STAR:  r = OP_MUL;
      CH_SLASH: r = OP_DIV;
      default:  r = OP_BAD;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/abc_if.sv
// Valid/ready channel interfaces for the text input and the result output.
// Depends on abc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface abc_text_if import abc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              is_last;

  modport source (output valid, char_in, is_last, input ready);
  modport sink   (input valid, char_in, is_last, output ready);
endinterface

interface abc_result_if import abc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic [ERR_W-1:0]         error_code;

  modport source (output valid, value, error_code, input ready);
  modport sink   (input valid, value, error_code, output ready);
endinterface

`default_nettype wire

FILE: rtl/abc_front.sv
// Front end: parses one text byte per cycle, while the queue has room, into operands and operator class.
// Depends on abc_pkg and abc_text_if; pushes one job per message.
`timescale 1ns / 1ps
`default_nettype none

module abc_front import abc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  abc_text_if.sink     text,
  output job_t         push_job,
  output logic         push_valid,
  input  wire logic    push_ready
);

  phase_t            phase, phase_next;
  logic [DATA_W-1:0] a, a_next;
  logic [DATA_W-1:0] b, b_next;
  op_t               op, op_next;

  logic              accept;
  logic              is_digit;
  logic [DATA_W-1:0] digit;
  logic [DATA_W-1:0] a_acc;
  logic [DATA_W-1:0] b_acc;

  assign text.ready = push_ready;
  assign accept     = text.valid && text.ready;

  // Decimal accumulate: x*10 + digit, wrapping
  assign is_digit = (text.char_in >= CH_ZERO) && (text.char_in <= CH_NINE);
  assign digit    = DATA_W'(text.char_in - CH_ZERO);
  assign a_acc    = {a[DATA_W-4:0], 3'b000} + {a[DATA_W-2:0], 1'b0} + digit;
  assign b_acc    = {b[DATA_W-4:0], 3'b000} + {b[DATA_W-2:0], 1'b0} + digit;

  // Advance the parser by one byte
  always_comb begin
    phase_next = phase;
    a_next     = a;
    b_next     = b;
    op_next    = op;
    unique case (phase)
      PH_FIRST: begin
        if (text.char_in == CH_NUL) begin
          phase_next = PH_DONE;
          op_next    = OP_BAD;
        end else if (is_digit) begin
          a_next = a_acc;
        end else begin
          op_next    = op_classify(text.char_in);
          phase_next = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (is_digit) begin
          b_next = b_acc;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
  end

  // Form the job on the last byte; no operator seen means an operator error
  assign push_job.a  = a_next;
  assign push_job.b  = b_next;
  assign push_job.op = (phase_next == PH_FIRST) ? OP_BAD : op_next;
  assign push_valid  = accept && text.is_last;

  // Hold parser state; restart after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
      a     <= '0;
      b     <= '0;
      op    <= OP_BAD;
    end else if (accept) begin
      if (text.is_last) begin
        phase <= PH_FIRST;
        a     <= '0;
        b     <= '0;
        op    <= OP_BAD;
      end else begin
        phase <= phase_next;
        a     <= a_next;
        b     <= b_next;
        op    <= op_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/abc_queue.sv
// Small register FIFO of parsed jobs between the front and back ends.
// Depends on abc_pkg for job_t.
`timescale 1ns / 1ps
`default_nettype none

module abc_queue import abc_pkg::*; #(
  parameter int unsigned DEPTH = ABC_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  job_t      push_job,
  input  wire logic push_valid,
  output logic      push_ready,
  output job_t      pop_job,
  output logic      pop_valid,
  input  wire logic pop_ready
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             ent [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = ent[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/abc_back.sv
// Back end: executes jobs (add, subtract, multiply, iterative signed divide).
// Depends on abc_pkg and abc_result_if; drives the registered result.
`timescale 1ns / 1ps
`default_nettype none

module abc_back import abc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  job_t        pop_job,
  input  wire logic   pop_valid,
  output logic        pop_ready,
  abc_result_if.source result
);

  back_state_t          state, state_next;
  logic                 res_valid;
  logic [DATA_W-1:0]    res_value;
  logic [ERR_W-1:0]     res_err;

  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    quo;
  logic [DATA_W-1:0]    dvs;
  logic                 neg;
  logic [DIV_CNT_W-1:0] cnt;

  logic                 out_free;
  logic                 div_nonzero;
  logic                 div_load;
  logic                 load_res;
  logic [DATA_W-1:0]    value_next;
  logic [ERR_W-1:0]     err_next;
  logic [DATA_W:0]      trial;
  logic [DATA_W:0]      diff;
  logic [DATA_W-1:0]    mag_a;
  logic [DATA_W-1:0]    mag_b;

  assign result.valid      = res_valid;
  assign result.value      = res_value;
  assign result.error_code = res_err;

  assign out_free    = !res_valid || result.ready;
  assign div_nonzero = (pop_job.op == OP_DIV) && (pop_job.b != '0);
  assign mag_a = pop_job.a[DATA_W-1] ? (~pop_job.a + 1'b1) : pop_job.a;
  assign mag_b = pop_job.b[DATA_W-1] ? (~pop_job.b + 1'b1) : pop_job.b;

  // One restoring division step
  assign trial = {rem, quo[DATA_W-1]};
  assign diff  = trial - {1'b0, dvs};

  // Sequence jobs and select the result
  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    div_load   = 1'b0;
    load_res   = 1'b0;
    value_next = '0;
    err_next   = ERR_OK;
    unique case (state)
      BK_IDLE: begin
        if (pop_valid) begin
          if (div_nonzero) begin
            pop_ready  = 1'b1;
            div_load   = 1'b1;
            state_next = BK_DIV;
          end else if (out_free) begin
            pop_ready = 1'b1;
            load_res  = 1'b1;
            unique case (pop_job.op)
              OP_ADD:  value_next = pop_job.a + pop_job.b;
              OP_SUB:  value_next = pop_job.a - pop_job.b;
              OP_MUL:  value_next = pop_job.a * pop_job.b;
              OP_DIV:  err_next   = ERR_DIV0;
              default: err_next   = ERR_OPER;
            endcase
          end
        end
      end
      BK_DIV: begin
        if (cnt == '1) begin
          state_next = BK_FIN;
        end
      end
      BK_FIN: begin
        if (out_free) begin
          load_res   = 1'b1;
          value_next = neg ? (~quo + 1'b1) : quo;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Load and step the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (div_load) begin
      cnt <= '0;
    end else if (state == BK_DIV) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      rem <= '0;
      quo <= mag_a;
      dvs <= mag_b;
      neg <= pop_job.a[DATA_W-1] ^ pop_job.b[DATA_W-1];
    end else if (state == BK_DIV) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_value <= value_next;
      res_err   <= err_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ascii_binary_expression_calculator.sv
// Top level of the ASCII infix integer calculator: front parser, job queue, back end.
// Depends on abc_pkg, abc_if, abc_front, abc_queue, abc_back and the assertion header.
//
//  channel  dir  fields               request
//  text     in   char_in, is_last     one text byte
//  result   out  value, error_code    one result per message
//
// Text bytes are taken one per cycle while the job queue has room.
// Add, subtract, multiply and error results are registered as the back end takes
// the job; a divide goes through load, 32 radix-2 steps in the divider and
// finish. The result register holds until taken.
// Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "ascii_binary_expression_calculator_assert.svh"

module ascii_binary_expression_calculator import abc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = ABC_QUEUE_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  abc_text_if.sink     text,
  abc_result_if.source result
);

  job_t push_job;
  logic push_valid;
  logic push_ready;
  job_t pop_job;
  logic pop_valid;
  logic pop_ready;

  // Parse bytes
  abc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // Decouple parser from execution
  abc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_job    (pop_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // Execute jobs
  abc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_job   (pop_job),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .result    (result)
  );

  // An error result carries a zero value
  `ABC_ASSERT_IMP(a_err_value_zero, result.valid && (result.error_code != ERR_OK), result.value == '0)
  // A message's last byte always leaves a job queued
  `ABC_ASSERT_NXT(a_last_queues_job, text.valid && text.ready && text.is_last, pop_valid)
  // A queued job not taken stays queued
  `ABC_ASSERT_NXT(a_queue_holds, pop_valid && !pop_ready, pop_valid)

endmodule

`default_nettype wire
